// ===== sv/dprq_pkg.sv =====
// Shared types and constants of the dynamic priority ready queue.
package dprq_pkg;

    localparam int MAX_RESULTS = 8;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_RUN    = 2'd1,
        ACT_LIST   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_INS  = 2'd1,
        OP_POP  = 2'd2,
        OP_ROT  = 2'd3
    } t_cell_op;

    typedef enum logic {
        CFG_PRIORITY_STEP = 1'b0,
        CFG_TIME_SLICE    = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]         id;
        logic signed [15:0] pri;
        logic [15:0]        used;
        logic [15:0]        total;
    } t_entry;

    // broadcast from the controller to every cell
    typedef struct packed {
        t_cell_op op;
        t_entry   ins;
    } t_cell_ctl;

endpackage

// ===== sv/dprq_cell.sv =====
// One queue slot: holds an entry and trades it with its neighbors.
module dprq_cell (
    input  logic                 i_clk,
    input  dprq_pkg::t_cell_ctl  i_ctl,
    input  dprq_pkg::t_entry     i_left,
    input  dprq_pkg::t_entry     i_right,
    input  dprq_pkg::t_entry     i_head,
    input  logic                 i_left_keep,
    input  logic                 i_occ,
    input  logic                 i_tail,
    output dprq_pkg::t_entry     o_entry,
    output logic                 o_keep
);
    import dprq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // entry stays put on insert when it ranks at or above the new one
    assign o_keep  = i_occ && ($signed(r_entry.pri) >= $signed(i_ctl.ins.pri));
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            OP_INS: begin
                if (!o_keep) begin
                    n_entry = i_left_keep ? i_ctl.ins : i_left;
                end
            end
            OP_POP:  n_entry = i_right;
            OP_ROT:  n_entry = i_tail ? i_head : i_right;
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== sv/dynamic_priority_ready_queue_unit.sv =====
// Insert gives one result. Run pops the head, then ages and reinserts it, and gives one result.
// List rotates the chain all the way round, one stored entry per step, and gives up to 8 results.
// A new item is taken only when the previous one is done and the output register is free.
// Synchronous active-low reset empties the queue and loads step 2, slice 4.
// Entry contents are not reset; slots past the fill count are never read.
module dynamic_priority_ready_queue_unit #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_action,
    input  logic [7:0]          i_proc_id,
    input  logic signed [15:0]  i_priority_req,
    input  logic [15:0]         i_used_time,
    input  logic [15:0]         i_total_time,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_status,
    output logic [7:0]          o_out_id,
    output logic signed [15:0]  o_out_priority,
    output logic [15:0]         o_out_used_time,
    output logic                o_finished,
    output logic                o_last
);
    import dprq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_LIST = 3'b100
    } t_state;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         id;
        logic signed [15:0] pri;
        logic [15:0]        used;
        logic               fin;
        logic               lst;
    } t_result;

    t_state    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_lk, n_lk;
    logic [7:0]  r_step;
    logic [15:0] r_slice;
    t_entry    r_head, n_head;
    logic      r_out_valid, n_out_valid;
    t_result   r_out, n_out;

    t_cell_ctl cell_ctl;
    t_entry    cell_q [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_keep;

    logic      out_free;
    logic      in_xfer;
    logic [16:0] pri_dec;
    logic [16:0] used_inc;
    logic signed [15:0] aged_pri;
    logic [15:0] aged_used;
    logic        aged_fin;
    logic [CW-1:0] list_lim;
    logic          list_emit;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_xfer    = i_in_valid && o_in_ready;

    // aging of the popped head
    assign pri_dec   = {r_head.pri[15], r_head.pri} - {9'd0, r_step};
    assign aged_pri  = (pri_dec[16] && !pri_dec[15]) ? 16'sh8000 : pri_dec[15:0];
    assign used_inc  = {1'b0, r_head.used} + {1'b0, r_slice};
    assign aged_used = used_inc[16] ? 16'hFFFF : used_inc[15:0];
    assign aged_fin  = (aged_used >= r_head.total);

    assign list_lim  = (int'(r_count) > MAX_RESULTS) ? CW'(MAX_RESULTS) : r_count;
    assign list_emit = (r_lk < list_lim);

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            dprq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (cell_ctl),
                .i_left      ((gi == 0) ? cell_q[gi] : cell_q[(gi == 0) ? 0 : gi - 1]),
                .i_right     ((gi == QUEUE_DEPTH - 1) ? cell_q[gi]
                              : cell_q[(gi == QUEUE_DEPTH - 1) ? gi : gi + 1]),
                .i_head      (cell_q[0]),
                .i_left_keep ((gi == 0) ? 1'b1 : cell_keep[(gi == 0) ? 0 : gi - 1]),
                .i_occ       (CW'(gi) < r_count),
                .i_tail      (CW'(gi + 1) == r_count),
                .o_entry     (cell_q[gi]),
                .o_keep      (cell_keep[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_lk         = r_lk;
        n_head       = r_head;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;
        cell_ctl.op  = OP_HOLD;
        cell_ctl.ins = '{id: i_proc_id, pri: i_priority_req,
                         used: i_used_time, total: i_total_time};

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (t_action'(i_action))
                        ACT_INSERT: begin
                            n_out_valid = 1'b1;
                            n_out = '{status: ST_OK, id: i_proc_id, pri: i_priority_req,
                                      used: i_used_time, fin: 1'b0, lst: 1'b1};
                            if (int'(r_count) == QUEUE_DEPTH) begin
                                n_out.status = ST_FULL;
                            end else begin
                                cell_ctl.op = OP_INS;
                                n_count     = r_count + 1'b1;
                            end
                        end
                        ACT_RUN: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_out = '{status: ST_EMPTY, id: '0, pri: '0,
                                          used: '0, fin: 1'b0, lst: 1'b1};
                            end else begin
                                n_head      = cell_q[0];
                                cell_ctl.op = OP_POP;
                                n_count     = r_count - 1'b1;
                                n_state     = S_RUN;
                            end
                        end
                        ACT_LIST: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_out = '{status: ST_EMPTY, id: '0, pri: '0,
                                          used: '0, fin: 1'b0, lst: 1'b1};
                            end else begin
                                n_lk    = '0;
                                n_state = S_LIST;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RUN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{status: ST_OK, id: r_head.id, pri: aged_pri,
                              used: aged_used, fin: aged_fin, lst: 1'b1};
                    if (!aged_fin) begin
                        cell_ctl.op  = OP_INS;
                        cell_ctl.ins = '{id: r_head.id, pri: aged_pri,
                                         used: aged_used, total: r_head.total};
                        n_count      = r_count + 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_LIST: begin
                // rotate the whole ring so the order is restored at the end
                if (!list_emit || out_free) begin
                    cell_ctl.op = OP_ROT;
                    if (list_emit) begin
                        n_out_valid = 1'b1;
                        n_out = '{status: ST_OK, id: cell_q[0].id, pri: cell_q[0].pri,
                                  used: cell_q[0].used, fin: 1'b0,
                                  lst: (r_lk + 1'b1 == list_lim)};
                    end
                    n_lk = r_lk + 1'b1;
                    if (r_lk + 1'b1 == r_count) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_lk        <= '0;
            r_out_valid <= 1'b0;
            r_step      <= 8'd2;
            r_slice     <= 16'd4;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_lk        <= n_lk;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_PRIORITY_STEP: r_step  <= i_cfg_data[7:0];
                    default:           r_slice <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_out  <= n_out;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_out_id        = r_out.id;
    assign o_out_priority  = r_out.pri;
    assign o_out_used_time = r_out.used;
    assign o_finished      = r_out.fin;
    assign o_last          = r_out.lst;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= QUEUE_DEPTH)
        else $error("fill count beyond queue depth");

    a_run_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (int'(r_count) < QUEUE_DEPTH))
        else $error("reinsert pending on a full queue");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_action == ACT_INSERT && int'(r_count) != QUEUE_DEPTH)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted insert did not grow the queue");

    a_list_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> (r_count != '0 && r_lk < r_count))
        else $error("list walk past the fill count");
`endif

endmodule
